### hdl/bfe_pkg.sv
`timescale 1ns / 1ps

package bfe_pkg;

   localparam int HASH_W     = 64;
   localparam int CNT_W      = 17;
   localparam int PROBE_W    = 5;
   localparam int DEF_MAX_BITS = 65536;
   localparam int MAX_PROBES = 16;
   localparam int DIV_STEPS  = HASH_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
   // The prime is 2^40 + 0x1B3, so the product is a shift plus a narrow multiply.
   localparam logic [8:0]        FNV_PRIME_LO = 9'h1B3;
   localparam int                FNV_PRIME_SHIFT = 40;

   typedef struct packed {
      logic absorb;
      logic fresh;
      logic mod_load;
      logic mod_sel;
      logic mod_wrap;
      logic mod_step;
      logic cap_idx;
      logic cap_step;
      logic cap_wrap;
      logic probe_wr;
      logic probe_rd;
      logic finish;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
   } status_type;

   function automatic logic [HASH_W-1:0] fnv_mult(input logic [HASH_W-1:0] x);
      logic [HASH_W-1:0] lo;
      lo = HASH_W'(x * FNV_PRIME_LO);
      return (x << FNV_PRIME_SHIFT) + lo;
   endfunction

endpackage

### hdl/bfe_ctrl.sv
`timescale 1ns / 1ps

module bfe_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          req_mode,
   input  logic                          req_last,
   input  logic [bfe_pkg::PROBE_W-1:0]   nprobes,
   input  bfe_pkg::status_type           status,
   output bfe_pkg::cmd_type              cmd,
   output logic                          busy
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_MOD_A, S_MOD_B, S_MOD_C, S_PROBE, S_DRAIN
   } state_type;

   state_type                       state_ff, state_in;
   logic                            open_ff, open_in;
   logic                            mode_ff, mode_in;
   logic [bfe_pkg::STEP_W-1:0]      cnt_ff, cnt_in;
   logic [bfe_pkg::PROBE_W-1:0]     pcnt_ff, pcnt_in;
   logic [bfe_pkg::PROBE_W-1:0]     probes;
   logic                            cnt_last;

   localparam logic [bfe_pkg::STEP_W-1:0] CntLast = bfe_pkg::STEP_W'(bfe_pkg::DIV_STEPS - 1);
   localparam logic [31:0] MaxProbesW = 32'(bfe_pkg::MAX_PROBES);

   always_comb begin
      if (nprobes == '0) begin
         probes = bfe_pkg::PROBE_W'(1);
      end else if (32'(nprobes) > MaxProbesW) begin
         probes = MaxProbesW[bfe_pkg::PROBE_W-1:0];
      end else begin
         probes = nprobes;
      end
   end

   assign cnt_last = (cnt_ff == CntLast);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      open_in  = open_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      pcnt_in  = pcnt_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.fresh = !open_ff;
            if (start) begin
               cmd.absorb = 1'b1;
               open_in    = !req_last;
               if (req_last) begin
                  cmd.mod_load = 1'b1;
                  mode_in      = req_mode;
                  cnt_in       = '0;
                  state_in     = S_MOD_A;
               end
            end
         end
         S_MOD_A: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               cmd.cap_idx  = 1'b1;
               cmd.mod_load = 1'b1;
               cmd.mod_sel  = 1'b1;
               state_in     = S_MOD_B;
            end
         end
         S_MOD_B: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               cmd.cap_step = 1'b1;
               cmd.mod_load = 1'b1;
               cmd.mod_wrap = 1'b1;
               state_in     = S_MOD_C;
            end
         end
         S_MOD_C: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               cmd.cap_wrap = 1'b1;
               pcnt_in      = '0;
               state_in     = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.probe_wr = !mode_ff;
            cmd.probe_rd = mode_ff;
            pcnt_in      = pcnt_ff + 1'b1;
            if (pcnt_ff == probes - 1'b1) begin
               state_in = mode_ff ? S_DRAIN : S_IDLE;
            end
         end
         S_DRAIN: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         open_ff  <= 1'b0;
         cnt_ff   <= '0;
         pcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         cnt_ff   <= cnt_in;
         pcnt_ff  <= pcnt_in;
      end
      mode_ff <= mode_in;
   end

endmodule

### hdl/bfe_datapath.sv
`timescale 1ns / 1ps

module bfe_datapath #(
   parameter int MAX_BITS = bfe_pkg::DEF_MAX_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfe_pkg::cmd_type              cmd,
   output bfe_pkg::status_type           status,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_has_byte,
   input  logic [bfe_pkg::CNT_W-1:0]     nbits,
   input  logic [bfe_pkg::HASH_W-1:0]    seed_one,
   input  logic [bfe_pkg::HASH_W-1:0]    seed_two,
   output logic                          rsp_valid,
   output logic                          rsp_maybe_present
);

   localparam int AW = $clog2(MAX_BITS);
   localparam logic [31:0] MaxBitsW = 32'(MAX_BITS);
   localparam logic [AW-1:0] ClrLast = AW'(MAX_BITS - 1);

   logic [bfe_pkg::HASH_W-1:0] h1_ff, h2_ff, h1_in, h2_in, h1_start, h2_start;
   logic [bfe_pkg::HASH_W-1:0] div_ff, v_ff;
   logic [bfe_pkg::HASH_W:0]   vsum;
   logic [bfe_pkg::CNT_W-1:0]  rem_ff, rem_next, idx_ff, step_ff, idx_next, m;
   logic [bfe_pkg::CNT_W-1:0]  wrap_ff, wrap_seed, mod_sum;
   logic [bfe_pkg::CNT_W:0]    trial, sum, m_ext, wrap_fix;
   logic [AW-1:0]              clr_ff, addr;
   logic                       store [MAX_BITS];
   logic                       rd_ff, rd_vld_ff, all_ff;
   logic                       rsp_valid_ff, rsp_maybe_ff;

   // Effective modulus: zero reads as one, large values saturate to the store size.
   always_comb begin
      if (nbits == '0) begin
         m = bfe_pkg::CNT_W'(1);
      end else if (32'(nbits) > MaxBitsW) begin
         m = MaxBitsW[bfe_pkg::CNT_W-1:0];
      end else begin
         m = nbits;
      end
   end
   assign m_ext = {1'b0, m};

   // Starting remainder for 2^64 mod m: one reduced modulo m.
   assign wrap_seed = (m == bfe_pkg::CNT_W'(1)) ? '0 : bfe_pkg::CNT_W'(1);

   always_comb begin
      h1_start = cmd.fresh ? (bfe_pkg::FNV_BASIS ^ seed_one) : h1_ff;
      h2_start = cmd.fresh ? (bfe_pkg::FNV_BASIS ^ (seed_two | 64'd1)) : h2_ff;
      if (req_has_byte) begin
         h1_in = bfe_pkg::fnv_mult(h1_start ^ {56'd0, req_key_byte});
         h2_in = bfe_pkg::fnv_mult(h2_start ^ {56'd0, req_key_byte});
      end else begin
         h1_in = h1_start;
         h2_in = h2_start;
      end
   end

   // One restoring step of the shared remainder unit, most significant bit first.
   // The probe index steps by h2 mod m; when the 64-bit running sum h1 + i*h2
   // wraps past 2^64, the residue is pulled back by 2^64 mod m.
   always_comb begin
      trial = {rem_ff, div_ff[bfe_pkg::HASH_W-1]};
      if (trial >= m_ext) begin
         rem_next = bfe_pkg::CNT_W'(trial - m_ext);
      end else begin
         rem_next = trial[bfe_pkg::CNT_W-1:0];
      end
      sum = {1'b0, idx_ff} + {1'b0, step_ff};
      if (sum >= m_ext) begin
         mod_sum = bfe_pkg::CNT_W'(sum - m_ext);
      end else begin
         mod_sum = sum[bfe_pkg::CNT_W-1:0];
      end
      vsum     = {1'b0, v_ff} + {1'b0, h2_ff};
      wrap_fix = {1'b0, mod_sum} + m_ext - {1'b0, wrap_ff};
      if (!vsum[bfe_pkg::HASH_W]) begin
         idx_next = mod_sum;
      end else if (mod_sum >= wrap_ff) begin
         idx_next = mod_sum - wrap_ff;
      end else begin
         idx_next = wrap_fix[bfe_pkg::CNT_W-1:0];
      end
   end

   assign addr = cmd.clear ? clr_ff : AW'(idx_ff);
   assign status.clr_done = (clr_ff == ClrLast);

   always_ff @(posedge clock) begin
      if (cmd.absorb) begin
         h1_ff <= h1_in;
         h2_ff <= h2_in;
      end
      if (cmd.mod_load) begin
         if (cmd.mod_wrap) begin
            div_ff <= '0;
            rem_ff <= wrap_seed;
         end else begin
            div_ff <= cmd.mod_sel ? h2_ff : h1_in;
            rem_ff <= '0;
         end
      end else if (cmd.mod_step) begin
         div_ff <= div_ff << 1;
         rem_ff <= rem_next;
      end
      if (cmd.cap_idx) begin
         idx_ff <= rem_next;
         v_ff   <= h1_ff;
      end else if (cmd.probe_wr || cmd.probe_rd) begin
         idx_ff <= idx_next;
         v_ff   <= vsum[bfe_pkg::HASH_W-1:0];
      end
      if (cmd.cap_step) begin
         step_ff <= rem_next;
      end
      if (cmd.cap_wrap) begin
         wrap_ff <= rem_next;
      end
      if (cmd.mod_load && !cmd.mod_sel) begin
         all_ff <= 1'b1;
      end else if (rd_vld_ff) begin
         all_ff <= all_ff & rd_ff;
      end
      rsp_maybe_ff <= all_ff & rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         store[addr] <= 1'b0;
      end else if (cmd.probe_wr) begin
         store[addr] <= 1'b1;
      end
      rd_ff <= store[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear && !status.clr_done) begin
            clr_ff <= clr_ff + 1'b1;
         end
         rd_vld_ff    <= cmd.probe_rd;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_maybe_ff;

endmodule

### hdl/bloom_filter_engine.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Word
// request   in         start & !busy          req_mode, req_key_byte, req_has_byte, req_last
// response  out        rsp_valid, one cycle   rsp_maybe_present
// csr       in/out     APB, pready always 1   64-bit registers at byte addresses 0, 8, 16, 24
//
// A key byte that is not the last is taken without busy rising.
// The last word of a key keeps the block busy while the bit-serial
// remainder unit reduces h1, h2 and 2^64 each modulo the bit count, then while
// it probes, and for a query while it collects the final store read.
// A query result is strobed on rsp_valid in the same cycle that busy falls.
// After reset the store is cleared one bit a cycle, all MAX_BITS of them, with busy high;
// register writes are taken throughout. The receiver cannot stall the response.
module bloom_filter_engine #(
   parameter int MAX_BITS = bfe_pkg::DEF_MAX_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_key_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic        rsp_maybe_present,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   typedef enum logic [1:0] {
      REG_NBITS, REG_NPROBES, REG_SEED_ONE, REG_SEED_TWO
   } reg_type;

   logic [bfe_pkg::CNT_W-1:0]   nbits_ff;
   logic [bfe_pkg::PROBE_W-1:0] nprobes_ff;
   logic [63:0]                 seed_one_ff, seed_two_ff;
   logic                        wr_en;
   reg_type                     reg_sel;
   bfe_pkg::cmd_type            cmd;
   bfe_pkg::status_type         status;

   // The register is picked by address bits 4:3; all four slots are defined.
   assign reg_sel = reg_type'(paddr[4:3]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nbits_ff    <= bfe_pkg::CNT_W'(65536);
         nprobes_ff  <= bfe_pkg::PROBE_W'(1);
         seed_one_ff <= 64'd0;
         seed_two_ff <= 64'd1;
      end else if (wr_en) begin
         case (reg_sel)
            REG_NBITS:    nbits_ff    <= pwdata[bfe_pkg::CNT_W-1:0];
            REG_NPROBES:  nprobes_ff  <= pwdata[bfe_pkg::PROBE_W-1:0];
            REG_SEED_ONE: seed_one_ff <= pwdata;
            REG_SEED_TWO: seed_two_ff <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_NBITS:    prdata = 64'(nbits_ff);
         REG_NPROBES:  prdata = 64'(nprobes_ff);
         REG_SEED_ONE: prdata = seed_one_ff;
         REG_SEED_TWO: prdata = seed_two_ff;
         default:      prdata = 64'd0;
      endcase
   end

   // The sequencer decides what happens each cycle; the datapath holds the
   // hashes, the shared remainder unit, the probe index and the bit store.
   bfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_mode   (req_mode),
      .req_last   (req_last),
      .nprobes    (nprobes_ff),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   bfe_datapath #(
      .MAX_BITS (MAX_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_key_byte      (req_key_byte),
      .req_has_byte      (req_has_byte),
      .nbits             (nbits_ff),
      .seed_one          (seed_one_ff),
      .seed_two          (seed_two_ff),
      .rsp_valid         (rsp_valid),
      .rsp_maybe_present (rsp_maybe_present)
   );

endmodule

### tb/bfe_tb_pkg.sv
`timescale 1ns / 1ps

package bfe_tb_pkg;

   // Register byte addresses (64-bit registers, so a stride of eight).
   localparam logic [4:0] ADDR_NBITS    = 5'd0;
   localparam logic [4:0] ADDR_NPROBES  = 5'd8;
   localparam logic [4:0] ADDR_SEED_ONE = 5'd16;
   localparam logic [4:0] ADDR_SEED_TWO = 5'd24;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

endpackage

### tb/bfe_checker.sv
`timescale 1ns / 1ps

module bfe_checker #(
   parameter int MAX_BITS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_key_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_maybe_present,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending,
   output int          results_seen,
   output int          inserts_seen
);

   localparam logic [63:0] BASIS = 64'hCBF29CE484222325;
   localparam logic [63:0] PRIME = 64'd1099511628211;

   logic [16:0]         nbits_reg;
   logic [4:0]          nprobes_reg;
   logic [63:0]         seed_one_reg;
   logic [63:0]         seed_two_reg;
   logic [63:0]         hash_one;
   logic [63:0]         hash_two;
   logic                key_open;
   logic [MAX_BITS-1:0] filter_bits;
   logic                presence_q[$];

   // Probes every position of the finished key; sets them on insert and
   // returns whether all were already set.
   function automatic logic probe_positions(input logic do_insert);
      logic [63:0] modulus;
      logic [63:0] probe_total;
      logic [63:0] pos;
      logic        all_set;
      modulus     = (nbits_reg == 0) ? 64'd1 :
                    (nbits_reg > MAX_BITS) ? 64'(MAX_BITS) : 64'(nbits_reg);
      probe_total = (nprobes_reg == 0) ? 64'd1 :
                    (nprobes_reg > 16) ? 64'd16 : 64'(nprobes_reg);
      all_set = 1'b1;
      for (int i = 0; i < probe_total; i++) begin
         pos = (hash_one + 64'(i) * hash_two) % modulus;
         if (do_insert) filter_bits[pos] = 1'b1;
         else if (!filter_bits[pos]) all_set = 1'b0;
      end
      return all_set;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         nbits_reg      = 17'd65536;
         nprobes_reg    = 5'd1;
         seed_one_reg   = '0;
         seed_two_reg   = 64'd1;
         key_open       = 1'b0;
         filter_bits    = '0;
         presence_q.delete();
         fail_count     = 0;
         pending        = 0;
         results_seen   = 0;
         inserts_seen   = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               bfe_tb_pkg::ADDR_NBITS:    nbits_reg    = pwdata[16:0];
               bfe_tb_pkg::ADDR_NPROBES:  nprobes_reg  = pwdata[4:0];
               bfe_tb_pkg::ADDR_SEED_ONE: seed_one_reg = pwdata;
               bfe_tb_pkg::ADDR_SEED_TWO: seed_two_reg = pwdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            results_seen++;
            if (presence_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected result word: maybe_present=%0b",
                           $realtime, rsp_maybe_present);
            end else begin
               logic want;
               want = presence_q.pop_front();
               if (want !== rsp_maybe_present) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("[%0t] maybe_present mismatch: expected %0b, got %0b",
                              $realtime, want, rsp_maybe_present);
               end
            end
         end
         if (start && !busy) begin
            if (!key_open) begin
               hash_one = BASIS ^ seed_one_reg;
               hash_two = BASIS ^ (seed_two_reg | 64'd1);
               key_open = 1'b1;
            end
            if (req_has_byte) begin
               hash_one = (hash_one ^ 64'(req_key_byte)) * PRIME;
               hash_two = (hash_two ^ 64'(req_key_byte)) * PRIME;
            end
            if (req_last) begin
               key_open = 1'b0;
               if (req_mode == bfe_tb_pkg::MODE_QUERY)
                  presence_q = {presence_q, probe_positions(1'b0)};
               else begin
                  void'(probe_positions(1'b1));
                  inserts_seen++;
               end
            end
         end
         pending = presence_q.size();
      end
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Top of the bench: drives key words and register writes into the Bloom filter
// engine, while the checker beside it predicts every query answer.
module testbench;

   // The block clears all 65536 store bits after reset with busy
   // high, so the watchdog must tolerate far more than one key's latency.
   localparam int WATCHDOG_LIMIT = 300000;
   // This margin covers the remainder and probe steps of a key's last word.
   localparam int SETTLE_CYCLES  = 250;
   localparam int RANDOM_ITEMS   = 1150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = 1'b0;
   logic [7:0]  req_key_byte = '0;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_maybe_present;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   int fail_count, pending, results_seen, inserts_seen;
   int words_sent = 0;
   int quiet_cycles = 0;
   bit steady_stretch = 1'b0;

   // A small history of inserted keys, so that many queries are real hits.
   logic [7:0] saved_bytes[32][8];
   int         saved_len[32];
   int         saved_total = 0;

   always #6 clock = ~clock;

   bloom_filter_engine u_dut (
      .clock, .reset, .start, .busy,
      .req_mode, .req_key_byte, .req_has_byte, .req_last,
      .rsp_valid, .rsp_maybe_present,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   bfe_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_mode, .req_key_byte, .req_has_byte, .req_last,
      .rsp_valid, .rsp_maybe_present,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .pending, .results_seen, .inserts_seen
   );

   // The watchdog is cleared by any accepted word, result or register write.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable && pwrite)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Presents one word and holds it until the block takes it. Start is left
   // high so the next word can follow straight on; a random idle gap lowers it.
   task automatic send_word(input logic mode, input logic [7:0] kbyte,
                            input logic has_byte, input logic last);
      start        <= 1'b1;
      req_mode     <= mode;
      req_key_byte <= kbyte;
      req_has_byte <= has_byte;
      req_last     <= last;
      do @(posedge clock); while (busy);
      words_sent++;
      if (!steady_stretch && $urandom_range(99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Sends a whole key. Words before the last carry a random mode, which the
   // block must ignore. With noise set, invalid words are mixed in.
   task automatic send_key(input logic mode, input logic [7:0] kb[8], input int len,
                           input bit noise);
      for (int i = 0; i < len; i++) begin
         if (noise && $urandom_range(9) == 0)
            send_word(1'($urandom), 8'($urandom), 1'b0, 1'b0);
         send_word((i == len - 1) ? mode : 1'($urandom), kb[i], 1'b1, i == len - 1);
      end
      // An empty key is a lone invalid last word; a noisy key may also close
      // with one.
      if (len == 0 || (noise && $urandom_range(19) == 0))
         send_word(mode, 8'($urandom), 1'b0, 1'b1);
      if (mode == bfe_tb_pkg::MODE_INSERT) begin
         saved_bytes[saved_total % 32] = kb;
         saved_len[saved_total % 32]   = len;
         saved_total++;
      end
   endtask

   task automatic csr_write(input logic [4:0] addr, input logic [63:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Waits until every query answer is in and an insert's probing must be over.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [63:0] bits, input logic [63:0] probes,
                            input logic [63:0] s1, input logic [63:0] s2);
      drain();
      csr_write(bfe_tb_pkg::ADDR_NBITS, bits);
      csr_write(bfe_tb_pkg::ADDR_NPROBES, probes);
      csr_write(bfe_tb_pkg::ADDR_SEED_ONE, s1);
      csr_write(bfe_tb_pkg::ADDR_SEED_TWO, s2);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic [7:0] kb[8];
      int         len;
      int         pick;
      int         phase_goal;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed keys under the reset settings: empty keys, extreme bytes,
      // an invalid word in mid-key and re-queries of what was inserted.
      foreach (kb[i]) kb[i] = 8'h00;
      send_key(bfe_tb_pkg::MODE_QUERY, kb, 0, 1'b0);
      send_key(bfe_tb_pkg::MODE_INSERT, kb, 0, 1'b0);
      send_key(bfe_tb_pkg::MODE_QUERY, kb, 0, 1'b0);
      send_key(bfe_tb_pkg::MODE_INSERT, kb, 1, 1'b0);
      send_key(bfe_tb_pkg::MODE_QUERY, kb, 1, 1'b0);
      foreach (kb[i]) kb[i] = 8'hFF;
      send_key(bfe_tb_pkg::MODE_QUERY, kb, 1, 1'b0);
      send_key(bfe_tb_pkg::MODE_INSERT, kb, 8, 1'b0);
      send_key(bfe_tb_pkg::MODE_QUERY, kb, 8, 1'b0);
      send_word(bfe_tb_pkg::MODE_INSERT, 8'h5A, 1'b1, 1'b0);
      send_word(bfe_tb_pkg::MODE_QUERY, 8'hA5, 1'b0, 1'b0);
      send_word(bfe_tb_pkg::MODE_INSERT, 8'h3C, 1'b1, 1'b1);
      send_word(bfe_tb_pkg::MODE_QUERY, 8'h5A, 1'b1, 1'b0);
      send_word(bfe_tb_pkg::MODE_INSERT, 8'h3C, 1'b1, 1'b1);
      send_word(bfe_tb_pkg::MODE_QUERY, 8'h5A, 1'b1, 1'b0);
      send_word(bfe_tb_pkg::MODE_INSERT, 8'h00, 1'b0, 1'b0);
      send_word(bfe_tb_pkg::MODE_QUERY, 8'h3C, 1'b1, 1'b1);

      // Six settings, extremes first; out-of-range counts must be clamped.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(64'd65536, 64'd16, rand64(), rand64());
            1: configure(64'd1, 64'd1, 64'd0, 64'd0);
            2: configure(64'd0, 64'd0, '1, 64'hFFFF_FFFF_FFFF_FFFE);
            3: configure(64'h1FFFF, 64'h1F, rand64(), rand64());
            4: configure(64'd97, 64'd4, rand64(), rand64() & ~64'd1);
            default: configure(64'($urandom_range(1, 65536)), 64'($urandom_range(1, 16)),
                               rand64(), rand64());
         endcase
         steady_stretch = (phase == 3);
         phase_goal = words_sent + RANDOM_ITEMS / 6;
         while (words_sent < phase_goal) begin
            pick = $urandom_range(99);
            if (pick < 35 && saved_total > 0) begin
               // Query a key inserted earlier, maybe under other settings.
               len = $urandom_range(saved_total < 32 ? saved_total - 1 : 31);
               send_key(bfe_tb_pkg::MODE_QUERY, saved_bytes[len], saved_len[len], 1'b0);
            end else begin
               foreach (kb[i]) kb[i] = 8'($urandom);
               len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
               send_key(pick < 70 ? bfe_tb_pkg::MODE_INSERT : bfe_tb_pkg::MODE_QUERY,
                        kb, len, pick >= 85);
            end
         end
      end

      drain();
      $display("Sent %0d key words under six register settings plus the reset one.",
               words_sent);
      $display("Inserted %0d keys and checked %0d query answers.", inserts_seen,
               results_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
